// ===== rtl/tksd_pkg.sv =====
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types, key codes and decode helpers for the terminal key decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_EOF  = 2'd2,
        CMD_INTR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [5:0]  key_code;
        logic [31:0] char_bytes;
        logic [2:0]  char_length;
    } t_result;

    // decode -> output stage
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_dec_out;

    localparam logic [15:0] ESC_TIMEOUT_RST = 16'd50;

    localparam logic [5:0] KEY_UNKNOWN   = 6'd0;
    localparam logic [5:0] KEY_ENTER     = 6'd1;
    localparam logic [5:0] KEY_TAB       = 6'd2;
    localparam logic [5:0] KEY_BACKSPACE = 6'd3;
    localparam logic [5:0] KEY_CTRL_A    = 6'd4;
    localparam logic [5:0] KEY_CTRL_D    = 6'd5;
    localparam logic [5:0] KEY_CTRL_E    = 6'd6;
    localparam logic [5:0] KEY_CTRL_G    = 6'd7;
    localparam logic [5:0] KEY_CTRL_K    = 6'd8;
    localparam logic [5:0] KEY_CTRL_L    = 6'd9;
    localparam logic [5:0] KEY_CTRL_N    = 6'd10;
    localparam logic [5:0] KEY_CTRL_O    = 6'd11;
    localparam logic [5:0] KEY_CTRL_P    = 6'd12;
    localparam logic [5:0] KEY_CTRL_R    = 6'd13;
    localparam logic [5:0] KEY_CTRL_T    = 6'd14;
    localparam logic [5:0] KEY_CTRL_U    = 6'd15;
    localparam logic [5:0] KEY_CTRL_W    = 6'd16;
    localparam logic [5:0] KEY_CTRL_X    = 6'd17;
    localparam logic [5:0] KEY_CTRL_Y    = 6'd18;
    localparam logic [5:0] KEY_ESCAPE    = 6'd19;
    localparam logic [5:0] KEY_ALT_ENTER = 6'd20;
    localparam logic [5:0] KEY_F1        = 6'd21;
    localparam logic [5:0] KEY_UP        = 6'd25;
    localparam logic [5:0] KEY_HOME      = 6'd29;
    localparam logic [5:0] KEY_END       = 6'd30;
    localparam logic [5:0] KEY_DELETE    = 6'd31;
    localparam logic [5:0] KEY_PAGE_UP   = 6'd32;
    localparam logic [5:0] KEY_PAGE_DOWN = 6'd33;
    localparam logic [5:0] KEY_F5        = 6'd34;
    localparam logic [5:0] KEY_F6        = 6'd35;
    localparam logic [5:0] KEY_F7        = 6'd36;
    localparam logic [5:0] KEY_F8        = 6'd37;
    localparam logic [5:0] KEY_F9        = 6'd38;
    localparam logic [5:0] KEY_F10       = 6'd39;
    localparam logic [5:0] KEY_F11       = 6'd40;
    localparam logic [5:0] KEY_F12       = 6'd41;
    localparam logic [5:0] KEY_CHAR      = 6'd42;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;

    function automatic logic [5:0] control_key(input logic [7:0] b);
        logic [5:0] k;
        unique case (b)
            8'h0A:        k = KEY_ENTER;
            8'h09:        k = KEY_TAB;
            8'h7F, 8'h08: k = KEY_BACKSPACE;
            8'h01:        k = KEY_CTRL_A;
            8'h04:        k = KEY_CTRL_D;
            8'h05:        k = KEY_CTRL_E;
            8'h07:        k = KEY_CTRL_G;
            8'h0B:        k = KEY_CTRL_K;
            8'h0C:        k = KEY_CTRL_L;
            8'h0E:        k = KEY_CTRL_N;
            8'h0F:        k = KEY_CTRL_O;
            8'h10:        k = KEY_CTRL_P;
            8'h12:        k = KEY_CTRL_R;
            8'h14:        k = KEY_CTRL_T;
            8'h15:        k = KEY_CTRL_U;
            8'h17:        k = KEY_CTRL_W;
            8'h18:        k = KEY_CTRL_X;
            8'h19:        k = KEY_CTRL_Y;
            default:      k = KEY_UNKNOWN;
        endcase
        return k;
    endfunction

    // UTF-8 sequence length from the lead byte; invalid leads count as one
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        priority if (b[7] == 1'b0)      n = 3'd1;
        else if (b[7:5] == 3'b110)      n = 3'd2;
        else if (b[7:4] == 4'b1110)     n = 3'd3;
        else if (b[7:3] == 5'b11110)    n = 3'd4;
        else                            n = 3'd1;
        return n;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

// ===== rtl/tksd_in_stage.sv =====
// ----------------------------------------------------------------------------
// tksd_in_stage
// Input register: holds one event until the decoder takes it.
// ----------------------------------------------------------------------------
module tksd_in_stage
    import tksd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    // nothing is taken while reset is held
    assign o_stall = !i_rst_n || (r_valid && !i_take);
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/tksd_decode.sv =====
// ----------------------------------------------------------------------------
// tksd_decode
// Parser state machine: one event per cycle unless a key waits on a full result register; at most one key per event.
// ----------------------------------------------------------------------------
module tksd_decode
    import tksd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic        i_out_ready,
    output logic        o_take,
    output t_dec_out    o_dec
);

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_ESC  = 6'b000010,
        MODE_SS3  = 6'b000100,
        MODE_CSI  = 6'b001000,
        MODE_NUM  = 6'b010000,
        MODE_UTF8 = 6'b100000
    } t_mode;

    t_mode       r_mode,    n_mode;
    logic [15:0] r_timeout;
    logic [15:0] r_ticks,   n_ticks;
    logic [23:0] r_bytes,   n_bytes;
    logic [2:0]  r_exp,     n_exp;
    logic [1:0]  r_cnt,     n_cnt;
    logic [3:0]  r_dig0,    n_dig0;
    logic [3:0]  r_dig1,    n_dig1;
    logic [1:0]  r_dcnt,    n_dcnt;

    logic        has_res;
    t_result     res;
    logic [7:0]  b;
    logic [15:0] tick_inc;
    logic [31:0] utf_word;
    logic [2:0]  utf_len;
    logic [5:0]  ctl_key;
    logic [2:0]  lead_n;
    logic [5:0]  num_key;

    assign b        = i_item.data_byte;
    assign tick_inc = r_ticks + 16'd1;
    assign utf_word = {8'h00, r_bytes} | ({24'h000000, b} << {r_cnt, 3'b000});
    assign utf_len  = {1'b0, r_cnt} + 3'd1;
    assign ctl_key  = control_key(b);
    assign lead_n   = lead_length(b);

    // numeric CSI keys; digits kept as BCD, leading zeros never match
    always_comb begin
        num_key = KEY_UNKNOWN;
        if (r_dcnt == 2'd1) begin
            unique case (r_dig0)
                4'd3:    num_key = KEY_DELETE;
                4'd5:    num_key = KEY_PAGE_UP;
                4'd6:    num_key = KEY_PAGE_DOWN;
                default: num_key = KEY_UNKNOWN;
            endcase
        end else if (r_dcnt == 2'd2) begin
            unique case ({r_dig0, r_dig1})
                8'h15:   num_key = KEY_F5;
                8'h17:   num_key = KEY_F6;
                8'h18:   num_key = KEY_F7;
                8'h19:   num_key = KEY_F8;
                8'h20:   num_key = KEY_F9;
                8'h21:   num_key = KEY_F10;
                8'h23:   num_key = KEY_F11;
                8'h24:   num_key = KEY_F12;
                default: num_key = KEY_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_ticks = r_ticks;
        n_bytes = r_bytes;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        n_dig0  = r_dig0;
        n_dig1  = r_dig1;
        n_dcnt  = r_dcnt;
        has_res = 1'b0;
        res     = '{key_code: KEY_UNKNOWN, char_bytes: 32'h0, char_length: 3'd0};

        unique case (i_item.cmd)
            CMD_INTR: begin
                has_res      = 1'b1;
                res.key_code = KEY_CTRL_D;
            end
            CMD_TICK: begin
                if (r_mode == MODE_ESC) begin
                    // a zero timeout behaves as one
                    if (tick_inc >= r_timeout || tick_inc == 16'd0) begin
                        has_res      = 1'b1;
                        res.key_code = KEY_ESCAPE;
                    end else begin
                        n_ticks = tick_inc;
                    end
                end
            end
            CMD_EOF: begin
                has_res = 1'b1;
                if (r_mode == MODE_ESC) begin
                    res.key_code = KEY_ESCAPE;
                end else if (r_mode == MODE_UTF8) begin
                    res.key_code    = KEY_CHAR;
                    res.char_bytes  = {8'h00, r_bytes};
                    res.char_length = {1'b0, r_cnt};
                end
            end
            CMD_BYTE: begin
                unique case (r_mode)
                    MODE_ESC: begin
                        if (b == BYTE_LF) begin
                            has_res      = 1'b1;
                            res.key_code = KEY_ALT_ENTER;
                        end else if (b == "O") begin
                            n_mode = MODE_SS3;
                        end else if (b == "[") begin
                            n_mode = MODE_CSI;
                        end else begin
                            has_res = 1'b1;
                        end
                    end
                    MODE_SS3: begin
                        has_res = 1'b1;
                        if (b >= "P" && b <= "S") begin
                            res.key_code = KEY_F1 + {4'd0, b[1:0]};
                        end
                    end
                    MODE_CSI: begin
                        if (b >= "A" && b <= "D") begin
                            has_res      = 1'b1;
                            res.key_code = KEY_UP + {4'd0, b[1:0] - 2'd1};
                        end else if (b == "H") begin
                            has_res      = 1'b1;
                            res.key_code = KEY_HOME;
                        end else if (b == "F") begin
                            has_res      = 1'b1;
                            res.key_code = KEY_END;
                        end else if (is_digit(b)) begin
                            n_mode = MODE_NUM;
                            n_dig0 = b[3:0];
                            n_dcnt = 2'd1;
                        end else begin
                            has_res = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        if (b == BYTE_TILDE) begin
                            has_res      = 1'b1;
                            res.key_code = num_key;
                        end else if (!is_digit(b) || r_dcnt == 2'd3) begin
                            // a fourth digit also ends the sequence
                            has_res = 1'b1;
                        end else begin
                            if (r_dcnt == 2'd1) begin
                                n_dig1 = b[3:0];
                            end
                            n_dcnt = r_dcnt + 2'd1;
                        end
                    end
                    MODE_UTF8: begin
                        if (utf_len == r_exp) begin
                            has_res         = 1'b1;
                            res.key_code    = KEY_CHAR;
                            res.char_bytes  = utf_word;
                            res.char_length = utf_len;
                        end else begin
                            n_bytes = utf_word[23:0];
                            n_cnt   = utf_len[1:0];
                        end
                    end
                    default: begin
                        if (ctl_key != KEY_UNKNOWN) begin
                            has_res      = 1'b1;
                            res.key_code = ctl_key;
                        end else if (b == BYTE_ESC) begin
                            n_mode  = MODE_ESC;
                            n_ticks = 16'd0;
                        end else if (b[7] && lead_n != 3'd1) begin
                            n_mode  = MODE_UTF8;
                            n_exp   = lead_n;
                            n_bytes = {16'h0000, b};
                            n_cnt   = 2'd1;
                        end else if (b[7] || (b >= 8'h20 && b < 8'h7F)) begin
                            has_res         = 1'b1;
                            res.key_code    = KEY_CHAR;
                            res.char_bytes  = {24'h000000, b};
                            res.char_length = 3'd1;
                        end else begin
                            has_res = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                has_res = 1'b0;
            end
        endcase

        if (has_res) begin
            n_mode = MODE_IDLE;
        end
    end

    // events that produce no key never wait on the output side
    assign o_take       = i_valid && (!has_res || i_out_ready);
    assign o_dec.valid  = o_take && has_res;
    assign o_dec.res    = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_ticks   <= 16'd0;
            r_timeout <= ESC_TIMEOUT_RST;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (o_take) begin
                r_mode  <= n_mode;
                r_ticks <= n_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bytes <= n_bytes;
            r_exp   <= n_exp;
            r_cnt   <= n_cnt;
            r_dig0  <= n_dig0;
            r_dig1  <= n_dig1;
            r_dcnt  <= n_dcnt;
        end
    end

    a_utf8_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_UTF8) |-> ({1'b0, r_cnt} < r_exp && r_cnt != 2'd0))
        else $error("utf8 collect count not below expected length");

    a_num_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUM) |-> (r_dcnt != 2'd0))
        else $error("csi digit count zero in numeric mode");

    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.valid && o_dec.res.key_code != KEY_CHAR)
            |-> (o_dec.res.char_length == 3'd0 && o_dec.res.char_bytes == 32'h0))
        else $error("non-character key carries bytes");

    a_idle_after_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid |=> (r_mode == MODE_IDLE))
        else $error("parser not idle after a key transfer");

endmodule

// ===== rtl/tksd_out_stage.sv =====
// ----------------------------------------------------------------------------
// tksd_out_stage
// Result register: holds a decoded key until the receiver takes it.
// ----------------------------------------------------------------------------
module tksd_out_stage
    import tksd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dec_out i_dec,
    output logic     o_ready,
    output logic     o_valid,
    output t_result  o_result,
    input  logic     i_stall
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_dec.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dec.valid) begin
            r_result <= i_dec.res;
        end
    end

    // no transfer is offered while reset is held
    assign o_valid  = r_valid && i_rst_n;
    assign o_result = r_result;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dec.valid |-> o_ready)
        else $error("result loaded while a stalled key is held");

endmodule

// ===== rtl/terminal_key_sequence_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_unit
// Decodes terminal bytes and events into key codes.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_item): one event per transfer, a byte,
// an idle tick, end of input or an interrupt. Output channel (o_valid /
// i_stall / o_result): one decoded key per transfer; an event yields zero or
// one key.
// Configuration: i_cfg_we writes i_cfg_wdata into the escape timeout (idle
// ticks after a lone ESC); reset value 50. Write only while the unit is idle.
// Path: an event taken on the input channel is held in the input register,
// decoded combinationally, and its key is loaded into the result register.
// Throughput: one event per cycle unless a key waits on a receiver stall, set
// by the parser update between the input register and the result register.
// Receiver stall: the held key stays on o_result; events that produce no key
// keep flowing; an event that would produce a key waits in the input register
// and o_stall rises when that register is full and cannot drain.
// Reset (i_rst_n low, synchronous): both registers empty, parser idle,
// timeout back to 50; o_stall high and o_valid low while reset is held.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_unit
    import tksd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result
);

    logic     in_valid;
    t_item    in_item;
    logic     take;
    logic     out_ready;
    t_dec_out dec;

    tksd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    tksd_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_ready (out_ready),
        .o_take      (take),
        .o_dec       (dec)
    );

    tksd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dec    (dec),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal key sequence decoder. A scoreboard
// class tracks the parser state, predicts the key, if any, of each input
// transfer and checks each output transfer in order. Plain tasks send
// directed and random events, random gaps and stalls, over seven timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tksd_pkg::*;

    typedef enum logic [2:0] {
        PM_IDLE,
        PM_ESC,
        PM_SS3,
        PM_CSI,
        PM_NUM,
        PM_UTF8
    } t_parse_mode;

    class key_scoreboard;
        logic [15:0] esc_timeout;
        t_parse_mode mode;
        logic [15:0] esc_ticks;
        logic [31:0] utf_bytes;
        logic [2:0]  utf_need;
        logic [2:0]  utf_have;
        logic [13:0] csi_value;
        logic [2:0]  csi_digits;
        t_result     pending_keys[$];
        int          errors;
        int          keys_checked;
        bit          code_seen[64];

        function new();
            esc_timeout = ESC_TIMEOUT_RST;
            errors = 0;
            keys_checked = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            mode = PM_IDLE;
            esc_ticks = '0;
            utf_bytes = '0;
            utf_need = '0;
            utf_have = '0;
            csi_value = '0;
            csi_digits = '0;
        endfunction

        function void expect_key(logic [5:0] code, logic [31:0] bytes = '0,
                                 logic [2:0] len = '0);
            t_result r;
            r.key_code = code;
            r.char_bytes = bytes;
            r.char_length = len;
            pending_keys = {pending_keys, r};
            clear_parse();
        endfunction

        function logic [5:0] ctrl_byte_key(logic [7:0] b);
            case (b)
                8'h0A:        return KEY_ENTER;
                8'h09:        return KEY_TAB;
                8'h08, 8'h7F: return KEY_BACKSPACE;
                8'h01:        return KEY_CTRL_A;
                8'h04:        return KEY_CTRL_D;
                8'h05:        return KEY_CTRL_E;
                8'h07:        return KEY_CTRL_G;
                8'h0B:        return KEY_CTRL_K;
                8'h0C:        return KEY_CTRL_L;
                8'h0E:        return KEY_CTRL_N;
                8'h0F:        return KEY_CTRL_O;
                8'h10:        return KEY_CTRL_P;
                8'h12:        return KEY_CTRL_R;
                8'h14:        return KEY_CTRL_T;
                8'h15:        return KEY_CTRL_U;
                8'h17:        return KEY_CTRL_W;
                8'h18:        return KEY_CTRL_X;
                8'h19:        return KEY_CTRL_Y;
                default:      return KEY_UNKNOWN;
            endcase
        endfunction

        // only exact digit strings match; "03" is not delete
        function logic [5:0] csi_number_key();
            if (csi_digits == 3'd1) begin
                case (csi_value)
                    14'd3:   return KEY_DELETE;
                    14'd5:   return KEY_PAGE_UP;
                    14'd6:   return KEY_PAGE_DOWN;
                    default: return KEY_UNKNOWN;
                endcase
            end else if (csi_digits == 3'd2) begin
                case (csi_value)
                    14'd15:  return KEY_F5;
                    14'd17:  return KEY_F6;
                    14'd18:  return KEY_F7;
                    14'd19:  return KEY_F8;
                    14'd20:  return KEY_F9;
                    14'd21:  return KEY_F10;
                    14'd23:  return KEY_F11;
                    14'd24:  return KEY_F12;
                    default: return KEY_UNKNOWN;
                endcase
            end
            return KEY_UNKNOWN;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [5:0] k;
            logic [2:0] n;
            case (mode)
                PM_ESC: begin
                    if (b == BYTE_LF) expect_key(KEY_ALT_ENTER);
                    else if (b == "O") mode = PM_SS3;
                    else if (b == "[") mode = PM_CSI;
                    else expect_key(KEY_UNKNOWN);
                end
                PM_SS3: begin
                    if (b >= "P" && b <= "S") expect_key(KEY_F1 + 6'(b[1:0]));
                    else expect_key(KEY_UNKNOWN);
                end
                PM_CSI: begin
                    case (b)
                        "A": expect_key(KEY_UP);
                        "B": expect_key(KEY_UP + 6'd1);
                        "C": expect_key(KEY_UP + 6'd2);
                        "D": expect_key(KEY_UP + 6'd3);
                        "H": expect_key(KEY_HOME);
                        "F": expect_key(KEY_END);
                        default: begin
                            if (b >= "0" && b <= "9") begin
                                mode = PM_NUM;
                                csi_value = 14'(b - "0");
                                csi_digits = 3'd1;
                            end else begin
                                expect_key(KEY_UNKNOWN);
                            end
                        end
                    endcase
                end
                PM_NUM: begin
                    if (b == BYTE_TILDE) begin
                        expect_key(csi_number_key());
                    end else if (b < "0" || b > "9") begin
                        expect_key(KEY_UNKNOWN);
                    end else begin
                        csi_value = 14'(csi_value * 10 + (b - "0"));
                        csi_digits++;
                        if (csi_digits >= 3'd4) expect_key(KEY_UNKNOWN);
                    end
                end
                PM_UTF8: begin
                    if (utf_have >= utf_need || utf_have >= 3'd4) begin
                        expect_key(KEY_CHAR, utf_bytes, utf_have);
                    end else begin
                        // continuation bytes are taken as they come
                        utf_bytes |= 32'(b) << (8 * utf_have);
                        utf_have++;
                        if (utf_have >= utf_need) expect_key(KEY_CHAR, utf_bytes, utf_have);
                    end
                end
                default: begin
                    k = ctrl_byte_key(b);
                    if (k != KEY_UNKNOWN) begin
                        expect_key(k);
                    end else if (b == BYTE_ESC) begin
                        clear_parse();
                        mode = PM_ESC;
                    end else if (b[7]) begin
                        casez (b)
                            8'b110?_????: n = 3'd2;
                            8'b1110_????: n = 3'd3;
                            8'b1111_0???: n = 3'd4;
                            default:      n = 3'd1;
                        endcase
                        if (n == 3'd1) begin
                            expect_key(KEY_CHAR, 32'(b), 3'd1);
                        end else begin
                            clear_parse();
                            mode = PM_UTF8;
                            utf_need = n;
                            utf_bytes = 32'(b);
                            utf_have = 3'd1;
                        end
                    end else if (b >= 8'h20 && b < 8'h7F) begin
                        expect_key(KEY_CHAR, 32'(b), 3'd1);
                    end else begin
                        expect_key(KEY_UNKNOWN);
                    end
                end
            endcase
        endfunction

        function void note_event(t_item it);
            case (it.cmd)
                CMD_INTR: expect_key(KEY_CTRL_D);
                CMD_BYTE: take_byte(it.data_byte);
                CMD_TICK: begin
                    // ticks only matter after a lone ESC; zero timeout acts as one
                    if (mode == PM_ESC) begin
                        esc_ticks++;
                        if (esc_ticks >= esc_timeout || esc_ticks == 16'd0)
                            expect_key(KEY_ESCAPE);
                    end
                end
                default: begin
                    if (mode == PM_ESC) expect_key(KEY_ESCAPE);
                    else if (mode == PM_UTF8) expect_key(KEY_CHAR, utf_bytes, utf_have);
                    else expect_key(KEY_UNKNOWN);
                end
            endcase
        endfunction

        function void check_key(t_result got);
            t_result want;
            if (pending_keys.size() == 0) begin
                $error("unexpected key transfer: key_code %0d", got.key_code);
                errors++;
            end else begin
                want = pending_keys.pop_front();
                keys_checked++;
                code_seen[want.key_code] = 1'b1;
                if (got.key_code !== want.key_code) begin
                    $error("key_code: expected %0d, got %0d", want.key_code, got.key_code);
                    errors++;
                end
                if (got.char_bytes !== want.char_bytes) begin
                    $error("char_bytes: expected %h, got %h", want.char_bytes,
                           got.char_bytes);
                    errors++;
                end
                if (got.char_length !== want.char_length) begin
                    $error("char_length: expected %0d, got %0d", want.char_length,
                           got.char_length);
                    errors++;
                end
            end
        endfunction

        function int codes_covered();
            int n;
            n = 0;
            foreach (code_seen[i]) if (code_seen[i]) n++;
            return n;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_item       i_item = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_result     o_result;

    key_scoreboard sb = new();

    int gap_max = 18;
    int stall_max = 18;
    int hold_cycles = 0;
    int events_sent = 0;

    terminal_key_sequence_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // values read here are the ones that held just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.esc_timeout = i_cfg_wdata;
            if (o_valid && !i_stall) sb.check_key(o_result);
            if (i_valid && !o_stall) sb.note_event(i_item);
        end
    end

    task automatic send_event(t_cmd c, logic [7:0] b);
        t_item it;
        int    gap;
        it.cmd = c;
        it.data_byte = b;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        events_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_event(CMD_BYTE, b);
    endtask

    task automatic run_receiver();
        int n;
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    endtask

    task automatic drain_keys();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_keys.size() != 0);
        // a last tick or partial sequence may still sit in the pipeline
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one key's worth of traffic, mostly well-formed sequences
    task automatic send_random_key();
        int         kind;
        int         len;
        int         cut;
        int         n;
        logic [7:0] b;
        int         csi_codes[11] = '{3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
        logic [7:0] csi_finals[6] = '{"A", "B", "C", "D", "H", "F"};
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 25) begin
            b = 8'($urandom_range(0, 32));
            send_byte((b == 8'd32) ? 8'h7F : b);
        end else if (kind < 45) begin
            len = $urandom_range(2, 4);
            b = 8'($urandom);
            case (len)
                2:       b = {3'b110, b[4:0]};
                3:       b = {4'b1110, b[3:0]};
                default: b = {5'b11110, b[2:0]};
            endcase
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : len;
            send_byte(b);
            for (int i = 1; i < cut; i++)
                send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)});
            if (cut < len) send_event($urandom_range(0, 1) ? CMD_EOF : CMD_INTR, 8'($urandom));
        end else if (kind < 50) begin
            // bytes that cannot lead a UTF-8 sequence
            b = 8'($urandom);
            send_byte(b[6] ? {5'b11111, b[2:0]} : {2'b10, b[5:0]});
        end else if (kind < 80) begin
            send_byte(BYTE_ESC);
            case ($urandom_range(0, 5))
                0: send_byte(BYTE_LF);
                1: begin
                    send_byte("O");
                    send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h50, 8'h53))
                                                  : 8'($urandom));
                end
                2: begin
                    send_byte("[");
                    send_byte($urandom_range(0, 3) ? csi_finals[$urandom_range(0, 5)]
                                                  : 8'($urandom));
                end
                3: begin
                    send_byte("[");
                    if ($urandom_range(0, 9) < 7) begin
                        n = csi_codes[$urandom_range(0, 10)];
                        if ($urandom_range(0, 9) == 0) send_byte("0");
                        if (n >= 10) send_byte(8'("0" + n / 10));
                        send_byte(8'("0" + n % 10));
                    end else begin
                        repeat ($urandom_range(1, 5)) send_byte(8'("0" + $urandom_range(0, 9)));
                    end
                    send_byte($urandom_range(0, 6) ? BYTE_TILDE : 8'($urandom));
                end
                4: begin
                    n = $urandom_range(0, (sb.esc_timeout <= 64) ? sb.esc_timeout + 2 : 40);
                    repeat (n) send_event(CMD_TICK, 8'($urandom));
                    send_event(t_cmd'($urandom_range(0, 3)), 8'($urandom));
                end
                default: send_event(t_cmd'($urandom_range(0, 3)), 8'($urandom));
            endcase
        end else if (kind < 92) begin
            send_event(t_cmd'($urandom_range(0, 3)), 8'($urandom));
        end else begin
            send_event($urandom_range(0, 1) ? CMD_EOF : CMD_INTR, 8'($urandom));
        end
    endtask

    initial begin
        logic [15:0] timeouts[7];
        int          start;
        timeouts = '{16'd50, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd7, 16'd2};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            run_receiver();
        join_none

        // directed: special bytes, numeric CSI corner cases, end of input, interrupt
        send_byte(8'hFF);
        send_byte(8'h20);
        send_byte(8'h7F);
        send_event(CMD_TICK, 8'h00);
        send_byte(BYTE_ESC);
        send_byte("[");
        send_byte("2");
        send_byte("4");
        send_byte(BYTE_TILDE);
        send_byte(BYTE_ESC);
        send_byte("[");
        send_byte("0");
        send_byte("3");
        send_byte(BYTE_TILDE);
        send_byte(BYTE_ESC);
        send_byte("[");
        send_byte("1");
        send_byte("2");
        send_byte("3");
        send_byte("4");
        send_byte(BYTE_TILDE);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_event(CMD_EOF, 8'hFF);
        send_event(CMD_EOF, 8'h00);
        send_byte(BYTE_ESC);
        send_byte("O");
        send_event(CMD_INTR, 8'h5A);
        send_byte(BYTE_ESC);
        send_event(CMD_EOF, 8'hA5);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                // leave the parser idle before touching the timeout
                send_event(CMD_INTR, 8'($urandom));
                drain_keys();
                write_timeout(timeouts[p]);
            end
            gap_max = (p % 3 == 1) ? 0 : 18;
            stall_max = (p % 3 == 2) ? 0 : 18;
            if (p == 3) begin
                gap_max = 0;
                hold_cycles = 250;
            end
            start = events_sent;
            while (events_sent - start < 190) send_random_key();
        end
        drain_keys();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d events, checked %0d keys, %0d of 43 key codes produced",
                 events_sent, sb.keys_checked, sb.codes_covered());
        $display("Escape timeouts 50, 1, 0, 3, 65535, 7, 2 with random gaps, stalls and a long hold-off");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout: run did not finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
